[rtl/binary_projection_histogram_assert.svh]
// Assertion macros shared by the histogram RTL.
`ifndef BINARY_PROJECTION_HISTOGRAM_ASSERT_SVH
`define BINARY_PROJECTION_HISTOGRAM_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define BPH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define BPH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define BPH_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BPH_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/bph_pkg.sv]
package bph_pkg;

    // Field and register widths
    localparam int COUNT_W   = 11;
    localparam int DIM_REG_W = 11;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_POS_W = 10;

    // Command codes
    localparam logic [1:0] CMD_PIXEL = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    // Reset values of the registers
    localparam logic                 MODE_RESET   = 1'b0;
    localparam logic [DIM_REG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [DIM_REG_W-1:0] HEIGHT_RESET = 11'd480;

    // Count saturation and bar pixel levels
    localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;
    localparam logic [7:0]         BAR_ON    = 8'd255;
    localparam logic [7:0]         BAR_OFF   = 8'd0;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] pixel_value;
    } t_in_req;

    typedef struct packed {
        logic [7:0]           bar_pixel;
        logic [OUT_POS_W-1:0] bar_row;
        logic [OUT_POS_W-1:0] bar_col;
        logic                 bar_last;
    } t_out_res;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIXEL,
        ST_EMIT
    } t_state;

endpackage

[rtl/bph_ram.sv]
module bph_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bph_out_reg.sv]
module bph_out_reg
    import bph_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_out_res i_res,
    output logic     o_free,
    output logic     o_valid,
    output t_out_res o_res,
    input  logic     i_ready
);

    logic     r_valid;
    t_out_res r_res;

    // Free when empty or being drained this cycle
    assign o_free = !r_valid || i_ready;

    // Hold the result until the request is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

[rtl/binary_projection_histogram.sv]
// Projection profile histogram of a binary image. Pixel requests (cmd 0) arrive in
// raster order and add to a per-column (mode 0) or per-row (mode 1) count held in a
// single-port-read count memory of MAX_DIM entries. A nonzero pixel reads its count in
// the idle state, then writes back the saturated increment and updates the largest
// count in the pixel state. A zero pixel, a pixel past the full frame, or an unknown
// command is taken without leaving the idle state. A read request (cmd 1) reads a
// count, then loads the bar pixel into the output register, waiting while that
// register stays full. A clear request (cmd 2), and also reset, starts a clearing
// pass that zeroes the count memory one entry per cycle, during which no request is
// accepted; configuration writes are taken at any time.
`include "binary_projection_histogram_assert.svh"

module binary_projection_histogram
    import bph_pkg::*;
#(
    parameter int MAX_DIM = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_REG_W-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_req              i_in_req,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_res             o_out_res
);

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int AW = $clog2(MAX_DIM);
    localparam int EW = (DW > DIM_REG_W) ? DW : DIM_REG_W;
    localparam int CW = (DW > COUNT_W) ? DW : COUNT_W;
    localparam int PW = CW + 1;

    // Registers
    logic                 r_mode;
    logic [DIM_REG_W-1:0] r_width;
    logic [DIM_REG_W-1:0] r_height;

    // Frame state
    t_state               r_state;
    t_state               n_state;
    logic [AW-1:0]        r_clr_addr;
    logic [COUNT_W-1:0]   r_largest;
    logic [DW-1:0]        r_in_row;
    logic [DW-1:0]        r_in_col;
    logic [PW-1:0]        r_out_row;
    logic [PW-1:0]        r_out_col;
    logic                 r_loaded;

    // Item in flight
    logic [AW-1:0]        r_idx;
    logic [PW-1:0]        r_em_row;
    logic [PW-1:0]        r_em_col;
    logic                 r_em_last;

    logic                 w_accept;
    logic                 w_pix_go;
    logic                 w_read_go;
    logic                 w_clear_go;
    logic                 w_out_free;
    logic                 w_out_load;
    t_out_res             w_res;

    logic [DW-1:0]        w_w_eff;
    logic [DW-1:0]        w_h_eff;

    logic [DW-1:0]        w_c0;
    logic [DW-1:0]        w_r0;
    logic [DW-1:0]        w_c1;
    logic [DW-1:0]        w_r1;
    logic                 w_end0;
    logic                 w_end1;
    logic [AW-1:0]        w_px_idx;

    logic [PW-1:0]        w_ow;
    logic [PW-1:0]        w_oh;
    logic [PW-1:0]        w_oc;
    logic [PW-1:0]        w_orw;
    logic [PW-1:0]        w_oc_next;
    logic [PW-1:0]        w_or_next;
    logic                 w_em_last;
    logic [AW-1:0]        w_em_idx;
    logic                 w_on;

    logic                 w_mem_we;
    logic [AW-1:0]        w_mem_waddr;
    logic [COUNT_W-1:0]   w_mem_wdata;
    logic                 w_mem_re;
    logic [AW-1:0]        w_mem_raddr;
    logic [COUNT_W-1:0]   w_rdata;
    logic [COUNT_W-1:0]   w_cnt_inc;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_RESET;
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MODE:   r_mode   <= i_cfg_data[0];
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp dimensions to 1..MAX_DIM
    always_comb begin
        if (EW'(r_width) == '0) begin
            w_w_eff = DW'(1);
        end else if (EW'(r_width) > EW'(MAX_DIM)) begin
            w_w_eff = DW'(MAX_DIM);
        end else begin
            w_w_eff = DW'(r_width);
        end
        if (EW'(r_height) == '0) begin
            w_h_eff = DW'(1);
        end else if (EW'(r_height) > EW'(MAX_DIM)) begin
            w_h_eff = DW'(MAX_DIM);
        end else begin
            w_h_eff = DW'(r_height);
        end
    end

    // Input raster position: wrap before the pixel, advance after it
    always_comb begin
        w_c0 = r_in_col;
        w_r0 = r_in_row;
        if (w_c0 >= w_w_eff) begin
            w_c0 = '0;
            w_r0 = r_in_row + 1'b1;
        end
        w_end0   = (w_r0 >= w_h_eff);
        w_px_idx = r_mode ? w_r0[AW-1:0] : w_c0[AW-1:0];
        w_c1     = w_c0 + 1'b1;
        w_r1     = w_r0;
        w_end1   = 1'b0;
        if (w_c1 >= w_w_eff) begin
            w_c1   = '0;
            w_r1   = w_r0 + 1'b1;
            w_end1 = (w_r1 >= w_h_eff);
        end
    end

    // Output raster position over the bar image
    always_comb begin
        w_ow  = r_mode ? PW'(r_largest) : PW'(w_w_eff);
        w_oh  = r_mode ? PW'(w_h_eff)   : PW'(r_largest);
        w_oc  = r_out_col;
        w_orw = r_out_row;
        if (w_oc >= w_ow) begin
            w_oc  = '0;
            w_orw = r_out_row + 1'b1;
        end
        if (w_orw >= w_oh) begin
            w_orw = '0;
        end
        w_em_idx  = r_mode ? w_orw[AW-1:0] : w_oc[AW-1:0];
        w_em_last = (PW'(w_orw + 1'b1) == w_oh) && (PW'(w_oc + 1'b1) == w_ow);
        if (w_em_last) begin
            w_oc_next = '0;
            w_or_next = '0;
        end else begin
            w_oc_next = w_oc + 1'b1;
            w_or_next = w_orw;
            if (w_oc_next >= w_ow) begin
                w_oc_next = '0;
                w_or_next = w_orw + 1'b1;
            end
        end
    end

    // Decode the accepted request
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_pix_go   = w_accept && (i_in_req.cmd == CMD_PIXEL) && !r_loaded && !w_end0
                        && (i_in_req.pixel_value != 8'd0);
    assign w_read_go  = w_accept && (i_in_req.cmd == CMD_READ) && r_loaded
                        && (r_largest != '0);
    assign w_clear_go = w_accept && (i_in_req.cmd == CMD_CLEAR);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == AW'(MAX_DIM - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                priority if (w_clear_go) begin
                    n_state = ST_CLEAR;
                end else if (w_pix_go) begin
                    n_state = ST_PIXEL;
                end else if (w_read_go) begin
                    n_state = ST_EMIT;
                end
            end
            ST_PIXEL: n_state = ST_IDLE;
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    // State outputs: handshake and memory ports
    always_comb begin
        o_in_ready  = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_waddr = r_idx;
        w_mem_wdata = w_cnt_inc;
        w_mem_re    = 1'b0;
        w_mem_raddr = w_px_idx;
        w_out_load  = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_clr_addr;
                w_mem_wdata = '0;
            end
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                w_mem_re    = w_pix_go || w_read_go;
                w_mem_raddr = w_read_go ? w_em_idx : w_px_idx;
            end
            ST_PIXEL: begin
                w_mem_we = 1'b1;
            end
            ST_EMIT: begin
                w_out_load = w_out_free;
            end
        endcase
    end

    // Saturating increment of the count just read
    assign w_cnt_inc = (w_rdata < COUNT_MAX) ? (w_rdata + 1'b1) : w_rdata;

    // Bar test for the pixel being emitted
    always_comb begin
        if (r_mode) begin
            w_on = (r_em_col < PW'(w_rdata));
        end else begin
            w_on = ((PW + 1)'(r_em_row) + (PW + 1)'(w_rdata)) >= (PW + 1)'(r_largest);
        end
    end

    always_comb begin
        w_res.bar_pixel = w_on ? BAR_ON : BAR_OFF;
        w_res.bar_row   = r_em_row[OUT_POS_W-1:0];
        w_res.bar_col   = r_em_col[OUT_POS_W-1:0];
        w_res.bar_last  = r_em_last;
    end

    // FSM and frame control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_largest  <= '0;
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_loaded   <= 1'b0;
        end else begin
            r_state <= n_state;
            // Advance the clearing sweep
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            // Start a new frame
            if (w_clear_go) begin
                r_clr_addr <= '0;
                r_largest  <= '0;
                r_in_row   <= '0;
                r_in_col   <= '0;
                r_out_row  <= '0;
                r_out_col  <= '0;
                r_loaded   <= 1'b0;
            end
            // Step the input raster on a pixel
            if (w_accept && (i_in_req.cmd == CMD_PIXEL) && !r_loaded) begin
                if (w_end0) begin
                    r_in_col <= w_c0;
                    r_in_row <= w_r0;
                    r_loaded <= 1'b1;
                end else begin
                    r_in_col <= w_c1;
                    r_in_row <= w_r1;
                    r_loaded <= w_end1;
                end
            end
            // Step the output raster on a read
            if (w_read_go) begin
                r_out_col <= w_oc_next;
                r_out_row <= w_or_next;
            end
            // Track the largest count
            if ((r_state == ST_PIXEL) && (w_cnt_inc > r_largest)) begin
                r_largest <= w_cnt_inc;
            end
        end
    end

    // Capture the item in flight
    always_ff @(posedge i_clk) begin
        if (w_pix_go) begin
            r_idx <= w_px_idx;
        end
        if (w_read_go) begin
            r_em_row  <= w_orw;
            r_em_col  <= w_oc;
            r_em_last <= w_em_last;
        end
    end

    bph_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (MAX_DIM)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_rdata)
    );

    bph_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_out_load),
        .i_res   (w_res),
        .o_free  (w_out_free),
        .o_valid (o_out_valid),
        .o_res   (o_out_res),
        .i_ready (i_out_ready)
    );

    // Largest count covers every count written back
    `BPH_ASSERT_NEXT(a_largest_covers, i_clk, i_rst_n, r_state == ST_PIXEL, r_largest >= $past(w_cnt_inc))
    // A clearing sweep leaves an empty, unloaded frame
    `BPH_ASSERT_NEXT(a_clear_empty, i_clk, i_rst_n, r_state == ST_CLEAR, (r_largest == '0) && !r_loaded)
    // A stalled result keeps the emit step waiting
    `BPH_ASSERT_NEXT(a_emit_hold, i_clk, i_rst_n, (r_state == ST_EMIT) && o_out_valid && !i_out_ready, r_state == ST_EMIT)
    // A read is started only on a loaded, nonempty frame
    `BPH_ASSERT_IMPL(a_read_loaded, i_clk, i_rst_n, w_read_go, r_loaded && (r_largest != '0))

endmodule
